@@ src/lc3_instruction_executor_unit_macros.svh @@
// ----------------------------------------------------------------------------
// lc3 executor assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LC3_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH

// same-cycle implication
`define LC3X_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lc3x assertion failed");

// next-cycle implication
`define LC3X_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lc3x assertion failed");

`endif

@@ src/lc3x_pkg.sv @@
// ----------------------------------------------------------------------------
// lc3x_pkg
// shared types, constants and helpers of the lc3 instruction executor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lc3x_pkg;

	localparam int ADDR_BITS  = 16;
	localparam int MEM_DEPTH  = 1 << ADDR_BITS;
	localparam int XLEN       = 16;
	localparam int RF_DEPTH   = 8;
	localparam int RF_IDX_W   = 3;
	localparam int CFG_ADDR_W = 3;

	localparam logic [XLEN-1:0] PC_RESET = 16'h3000;
	localparam logic            CFG_IDX_START_PC = 1'b0;

	localparam logic [2:0] FLAG_N = 3'b100;
	localparam logic [2:0] FLAG_Z = 3'b010;
	localparam logic [2:0] FLAG_P = 3'b001;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CHAR    = 3'd1;
	localparam logic [2:0] ST_HALT    = 3'd2;
	localparam logic [2:0] ST_ILLEGAL = 3'd3;
	localparam logic [2:0] ST_HOST    = 3'd4;

	localparam logic [3:0] OPC_BR   = 4'd0;
	localparam logic [3:0] OPC_ADD  = 4'd1;
	localparam logic [3:0] OPC_LD   = 4'd2;
	localparam logic [3:0] OPC_ST   = 4'd3;
	localparam logic [3:0] OPC_JSR  = 4'd4;
	localparam logic [3:0] OPC_AND  = 4'd5;
	localparam logic [3:0] OPC_LDR  = 4'd6;
	localparam logic [3:0] OPC_STR  = 4'd7;
	localparam logic [3:0] OPC_NOT  = 4'd9;
	localparam logic [3:0] OPC_LDI  = 4'd10;
	localparam logic [3:0] OPC_STI  = 4'd11;
	localparam logic [3:0] OPC_JMP  = 4'd12;
	localparam logic [3:0] OPC_LEA  = 4'd14;
	localparam logic [3:0] OPC_TRAP = 4'd15;

	localparam logic [7:0] TV_GETC = 8'h20;
	localparam logic [7:0] TV_OUT  = 8'h21;
	localparam logic [7:0] TV_IN   = 8'h23;
	localparam logic [7:0] TV_HALT = 8'h25;

	localparam logic [RF_IDX_W-1:0] REG_R0 = 3'd0;
	localparam logic [RF_IDX_W-1:0] REG_R7 = 3'd7;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_READ    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_EXEC    = 2'd3
	} lc3x_op_t;

	typedef struct packed {
		lc3x_op_t        operation;
		logic [15:0]     address;
		logic [15:0]     data;
		logic [7:0]      key_char;
	} lc3x_cmd_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [15:0]     read_data;
		logic [15:0]     next_pc;
		logic [15:0]     executed_instr;
		logic [7:0]      out_char;
		logic [7:0]      trap_vector;
	} lc3x_res_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_BITS-1:0] waddr;
		logic [XLEN-1:0]      wdata;
		logic                 re;
		logic [ADDR_BITS-1:0] raddr;
	} lc3x_mem_req_t;

	typedef struct packed {
		logic                we;
		logic [RF_IDX_W-1:0] waddr;
		logic [XLEN-1:0]     wdata;
		logic                re;
		logic [RF_IDX_W-1:0] raddr;
	} lc3x_rf_req_t;

	function automatic logic [2:0] flags_of(input logic [XLEN-1:0] v);
		if (v == '0) begin
			return FLAG_Z;
		end else if (v[XLEN-1]) begin
			return FLAG_N;
		end else begin
			return FLAG_P;
		end
	endfunction

endpackage

@@ src/lc3x_ram.sv @@
// ----------------------------------------------------------------------------
// lc3x_ram
// generic one-write one-read synchronous ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lc3x_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/lc3x_core.sv @@
// ----------------------------------------------------------------------------
// lc3x_core
// command sequencer and datapath: fetch, register reads, execute, memory steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lc3x_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  lc3x_pkg::lc3x_cmd_t     cmd,
	input  logic [15:0]             start_pc,
	output logic                    busy,
	output logic                    done,
	output lc3x_pkg::lc3x_res_t     result,
	output lc3x_pkg::lc3x_mem_req_t mem_req,
	input  logic [15:0]             mem_rdata,
	output lc3x_pkg::lc3x_rf_req_t  rf_req,
	input  logic [15:0]             rf_rdata
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_MRD    = 9'b000000010,
		S_FETCH  = 9'b000000100,
		S_RFA    = 9'b000001000,
		S_RFB    = 9'b000010000,
		S_MEM1   = 9'b000100000,
		S_MEM2   = 9'b001000000,
		S_TRAPR0 = 9'b010000000,
		S_RESP   = 9'b100000000
	} state_t;

	state_t                 state_q, state_d;
	lc3x_pkg::lc3x_cmd_t    cmd_q, cmd_d;
	logic [15:0]            pc_q, pc_d;
	logic [2:0]             flags_q, flags_d;
	logic                   halted_q, halted_d;
	logic [15:0]            instr_q, instr_d;
	logic [15:0]            a_q, a_d;
	logic [15:0]            b_q, b_d;
	logic [2:0]             status_q, status_d;
	logic [15:0]            rdata_q, rdata_d;
	logic [7:0]             ochar_q, ochar_d;
	logic [7:0]             vec_q, vec_d;
	logic [lc3x_pkg::RF_DEPTH-1:0] rf_valid_q;
	logic                   rf_rvalid_q;
	logic                   set_flags;

	logic [3:0]             opc;
	logic [2:0]             dr;
	logic [15:0]            rf_val;
	logic [15:0]            off9, off6, off11, imm5;
	logic [15:0]            pc_off9, ea, alu_b, alu_res;
	logic [2:0]             b_addr;

	assign opc     = instr_q[15:12];
	assign dr      = instr_q[11:9];
	assign rf_val  = rf_rvalid_q ? rf_rdata : '0;
	assign off9    = {{7{instr_q[8]}}, instr_q[8:0]};
	assign off6    = {{10{instr_q[5]}}, instr_q[5:0]};
	assign off11   = {{5{instr_q[10]}}, instr_q[10:0]};
	assign imm5    = {{11{instr_q[4]}}, instr_q[4:0]};
	assign pc_off9 = pc_q + off9;
	assign ea      = (opc == lc3x_pkg::OPC_LDR || opc == lc3x_pkg::OPC_STR) ?
			(a_q + off6) : pc_off9;
	assign alu_b   = instr_q[5] ? imm5 : rf_val;
	assign alu_res = (opc == lc3x_pkg::OPC_ADD) ? (a_q + alu_b) :
			(opc == lc3x_pkg::OPC_AND) ? (a_q & alu_b) : ~a_q;

	always_comb begin
		if (opc == lc3x_pkg::OPC_ST || opc == lc3x_pkg::OPC_STI ||
				opc == lc3x_pkg::OPC_STR) begin
			b_addr = dr;
		end else if (opc == lc3x_pkg::OPC_TRAP) begin
			b_addr = lc3x_pkg::REG_R0;
		end else begin
			b_addr = instr_q[2:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		pc_d      = pc_q;
		flags_d   = flags_q;
		halted_d  = halted_q;
		instr_d   = instr_q;
		a_d       = a_q;
		b_d       = b_q;
		status_d  = status_q;
		rdata_d   = rdata_q;
		ochar_d   = ochar_q;
		vec_d     = vec_q;
		mem_req   = '0;
		rf_req    = '0;
		set_flags = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_d    = cmd;
					status_d = lc3x_pkg::ST_OK;
					rdata_d  = '0;
					instr_d  = '0;
					ochar_d  = '0;
					vec_d    = '0;
					unique case (cmd.operation)
						lc3x_pkg::CMD_WRITE: begin
							mem_req.we    = 1'b1;
							mem_req.waddr = cmd.address[lc3x_pkg::ADDR_BITS-1:0];
							mem_req.wdata = cmd.data;
							state_d       = S_RESP;
						end
						lc3x_pkg::CMD_READ: begin
							mem_req.re    = 1'b1;
							mem_req.raddr = cmd.address[lc3x_pkg::ADDR_BITS-1:0];
							state_d       = S_MRD;
						end
						lc3x_pkg::CMD_RESTART: begin
							pc_d     = start_pc;
							flags_d  = lc3x_pkg::FLAG_Z;
							halted_d = 1'b0;
							state_d  = S_RESP;
						end
						lc3x_pkg::CMD_EXEC: begin
							if (halted_q) begin
								status_d = lc3x_pkg::ST_HALT;
								state_d  = S_RESP;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = pc_q[lc3x_pkg::ADDR_BITS-1:0];
								state_d       = S_FETCH;
							end
						end
					endcase
				end
			end
			S_MRD: begin
				rdata_d = mem_rdata;
				state_d = S_RESP;
			end
			S_FETCH: begin
				instr_d      = mem_rdata;
				pc_d         = pc_q + 16'd1;
				rf_req.re    = 1'b1;
				rf_req.raddr = mem_rdata[8:6];
				state_d      = S_RFA;
			end
			S_RFA: begin
				a_d          = rf_val;
				rf_req.re    = 1'b1;
				rf_req.raddr = b_addr;
				state_d      = S_RFB;
			end
			S_RFB: begin
				b_d     = rf_val;
				state_d = S_RESP;
				unique case (opc)
					lc3x_pkg::OPC_ADD, lc3x_pkg::OPC_AND, lc3x_pkg::OPC_NOT: begin
						rf_req.we    = 1'b1;
						rf_req.waddr = dr;
						rf_req.wdata = alu_res;
						set_flags    = 1'b1;
					end
					lc3x_pkg::OPC_BR: begin
						if ((dr & flags_q) != 3'b000) begin
							pc_d = pc_off9;
						end
					end
					lc3x_pkg::OPC_JMP: begin
						pc_d = a_q;
					end
					lc3x_pkg::OPC_JSR: begin
						pc_d         = instr_q[11] ? (pc_q + off11) : a_q;
						rf_req.we    = 1'b1;
						rf_req.waddr = lc3x_pkg::REG_R7;
						rf_req.wdata = pc_q;
					end
					lc3x_pkg::OPC_LD, lc3x_pkg::OPC_LDI, lc3x_pkg::OPC_LDR,
					lc3x_pkg::OPC_STI: begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ea[lc3x_pkg::ADDR_BITS-1:0];
						state_d       = S_MEM1;
					end
					lc3x_pkg::OPC_ST, lc3x_pkg::OPC_STR: begin
						mem_req.we    = 1'b1;
						mem_req.waddr = ea[lc3x_pkg::ADDR_BITS-1:0];
						mem_req.wdata = rf_val;
					end
					lc3x_pkg::OPC_LEA: begin
						rf_req.we    = 1'b1;
						rf_req.waddr = dr;
						rf_req.wdata = pc_off9;
						set_flags    = 1'b1;
					end
					lc3x_pkg::OPC_TRAP: begin
						rf_req.we    = 1'b1;
						rf_req.waddr = lc3x_pkg::REG_R7;
						rf_req.wdata = pc_q;
						vec_d        = instr_q[7:0];
						unique case (instr_q[7:0])
							lc3x_pkg::TV_GETC: begin
								state_d = S_TRAPR0;
							end
							lc3x_pkg::TV_OUT: begin
								status_d = lc3x_pkg::ST_CHAR;
								ochar_d  = rf_val[7:0];
							end
							lc3x_pkg::TV_IN: begin
								status_d = lc3x_pkg::ST_CHAR;
								ochar_d  = cmd_q.key_char;
								state_d  = S_TRAPR0;
							end
							lc3x_pkg::TV_HALT: begin
								status_d = lc3x_pkg::ST_HALT;
								halted_d = 1'b1;
							end
							default: begin
								status_d = lc3x_pkg::ST_HOST;
							end
						endcase
					end
					default: begin
						status_d = lc3x_pkg::ST_ILLEGAL;
						halted_d = 1'b1;
					end
				endcase
			end
			S_MEM1: begin
				state_d = S_RESP;
				priority if (opc == lc3x_pkg::OPC_LDI) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = mem_rdata[lc3x_pkg::ADDR_BITS-1:0];
					state_d       = S_MEM2;
				end else if (opc == lc3x_pkg::OPC_STI) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = mem_rdata[lc3x_pkg::ADDR_BITS-1:0];
					mem_req.wdata = b_q;
				end else begin
					rf_req.we    = 1'b1;
					rf_req.waddr = dr;
					rf_req.wdata = mem_rdata;
					set_flags    = 1'b1;
				end
			end
			S_MEM2: begin
				rf_req.we    = 1'b1;
				rf_req.waddr = dr;
				rf_req.wdata = mem_rdata;
				set_flags    = 1'b1;
				state_d      = S_RESP;
			end
			S_TRAPR0: begin
				rf_req.we    = 1'b1;
				rf_req.waddr = lc3x_pkg::REG_R0;
				rf_req.wdata = {8'h00, cmd_q.key_char};
				set_flags    = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (set_flags) begin
			flags_d = lc3x_pkg::flags_of(rf_req.wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= lc3x_pkg::PC_RESET;
			flags_q     <= lc3x_pkg::FLAG_Z;
			halted_q    <= 1'b0;
			rf_valid_q  <= '0;
			rf_rvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pc_q     <= pc_d;
			flags_q  <= flags_d;
			halted_q <= halted_d;
			if (rf_req.we) begin
				rf_valid_q[rf_req.waddr] <= 1'b1;
			end
			if (rf_req.re) begin
				rf_rvalid_q <= rf_valid_q[rf_req.raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		instr_q  <= instr_d;
		a_q      <= a_d;
		b_q      <= b_d;
		status_q <= status_d;
		rdata_q  <= rdata_d;
		ochar_q  <= ochar_d;
		vec_q    <= vec_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

	assign result.status         = status_q;
	assign result.read_data      = rdata_q;
	assign result.next_pc        = pc_q;
	assign result.executed_instr = instr_q;
	assign result.out_char       = ochar_q;
	assign result.trap_vector    = vec_q;

endmodule

@@ src/lc3_instruction_executor_unit.sv @@
// states from accept to done (resp): write, restart and halted execute go straight to resp; read passes mrd;
// alu, lea, branch, jump, store, other traps and illegal opcodes pass fetch, rfa and rfb;
// ld, ldr and sti add mem1, getc/in add trapr0, and ldi adds mem1 and mem2 after rfb
// busy falls the cycle after done; a new word is taken only when idle; results never stall
// fetch, two register reads and up to two dependent memory reads go through one-write one-read rams
// reset: registers read zero, pc 0x3000, flags z, running; memory undefined until written
// ----------------------------------------------------------------------------
// lc3_instruction_executor_unit
// lc3 core top level: apb start address register, sequencer, memory and register file
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lc3_instruction_executor_unit_macros.svh"

module lc3_instruction_executor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  lc3x_pkg::lc3x_cmd_t               cmd,
	output logic                              done,
	output lc3x_pkg::lc3x_res_t               result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lc3x_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [15:0]             start_pc_q;
	logic                    cfg_sel;
	lc3x_pkg::lc3x_mem_req_t mem_req;
	lc3x_pkg::lc3x_rf_req_t  rf_req;
	logic [15:0]             mem_rdata;
	logic [15:0]             rf_rdata;

	assign pready  = 1'b1;
	assign cfg_sel = (paddr[lc3x_pkg::CFG_ADDR_W-1] == lc3x_pkg::CFG_IDX_START_PC);
	assign prdata  = cfg_sel ? {16'h0000, start_pc_q} : 32'h0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= lc3x_pkg::PC_RESET;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			start_pc_q <= pwdata[15:0];
		end
	end

	lc3x_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.start_pc  (start_pc_q),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.rf_req    (rf_req),
		.rf_rdata  (rf_rdata)
	);

	lc3x_ram #(
		.WIDTH (lc3x_pkg::XLEN),
		.DEPTH (lc3x_pkg::MEM_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	lc3x_ram #(
		.WIDTH (lc3x_pkg::XLEN),
		.DEPTH (lc3x_pkg::RF_DEPTH)
	) u_rf (
		.clk   (clk),
		.we    (rf_req.we),
		.waddr (rf_req.waddr),
		.wdata (rf_req.wdata),
		.re    (rf_req.re),
		.raddr (rf_req.raddr),
		.rdata (rf_rdata)
	);

	`LC3X_ASSERT_NEXT(a_done_single, done, !done)
	`LC3X_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`LC3X_ASSERT_SAME(a_mem_one_access, mem_req.we, !mem_req.re)
	`LC3X_ASSERT_SAME(a_rf_write_busy, rf_req.we, busy && !done)

endmodule
